// File: src/mmvp_pkg.sv
// Shared types and constants for the mono MIDI voice pitch controller.
// No dependencies.
`default_nettype none

package mmvp_pkg;

  localparam int NOTE_COUNT_DEF = 128;

  typedef enum logic [1:0] {
    OP_MIDI  = 2'd0,
    OP_TICK  = 2'd1,
    OP_TABLE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RS_NONE,
    RS_ON,
    RS_OFF,
    RS_CC,
    RS_PB
  } rs_t;

  typedef enum logic [2:0] {
    K_NOP,
    K_TABLE,
    K_TICK,
    K_STATUS,
    K_DATA
  } kind_t;

  typedef enum logic [2:0] {
    REG_LISTEN    = 3'd0,
    REG_FINE_CC   = 3'd1,
    REG_EN_CC     = 3'd2,
    REG_DIR_CC    = 3'd3,
    REG_AMT_CC    = 3'd4,
    REG_LOOP_CC   = 3'd5,
    REG_MIN_PER   = 3'd6,
    REG_MAX_PER   = 3'd7
  } reg_t;

  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_CC       = 4'hB;
  localparam logic [3:0] HI_BEND     = 4'hE;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;

  // x / 192 = ((x >> 6) * FINE_RECIP3) >> 17, exact for x below 2^23
  localparam logic [15:0] FINE_RECIP3 = 16'd43691;
  localparam logic [6:0]  BEND_MID    = 7'd63;
  localparam logic [6:0]  BEND_SPAN   = 7'd64;
  localparam logic [6:0]  CC_THRESH   = 7'd64;

  localparam logic [3:0]  RST_LISTEN  = 4'd0;
  localparam logic [6:0]  RST_FINE_CC = 7'd1;
  localparam logic [6:0]  RST_EN_CC   = 7'd2;
  localparam logic [6:0]  RST_DIR_CC  = 7'd3;
  localparam logic [6:0]  RST_AMT_CC  = 7'd4;
  localparam logic [6:0]  RST_LOOP_CC = 7'd5;
  localparam logic [15:0] RST_MIN_PER = 16'd100;
  localparam logic [15:0] RST_MAX_PER = 16'd65000;
  localparam logic [15:0] RST_PERIOD  = 16'd500;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  midi_byte;
    logic [6:0]  table_index;
    logic [15:0] table_value;
  } item_t;

  typedef struct packed {
    logic [15:0] period_out;
    logic        period_updated;
    logic        gate;
    logic        phase_restart;
  } result_t;

  typedef struct packed {
    kind_t       kind;
    rs_t         rs;
    logic [7:0]  midi_byte;
    logic [6:0]  table_index;
    logic [15:0] table_value;
  } entry_t;

  typedef struct packed {
    logic [3:0]  listen_channel;
    logic [6:0]  fine_ctrl;
    logic [6:0]  sweep_enable_cc;
    logic [6:0]  dir_ctrl;
    logic [6:0]  step_ctrl;
    logic [6:0]  sweep_loop_cc;
    logic [15:0] min_period;
    logic [15:0] max_period;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/mmvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mmvp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/mmvp_fifo.sv
// Two-entry queue between the classifier and the execution sequencer.
// Depends on mmvp_pkg.
`default_nettype none

module mmvp_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mmvp_pkg::entry_t wdata,
  output logic             full,
  input  logic             pop,
  output mmvp_pkg::entry_t rdata,
  output logic             empty
);
  import mmvp_pkg::*;

  entry_t     mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

endmodule

`default_nettype wire

// File: src/mmvp_front.sv
// Input classifier: sorts each transaction into table write, tick, status, data or no-op.
// Depends on mmvp_pkg.
`default_nettype none

module mmvp_front (
  input  logic             item_valid,
  output logic             item_stall,
  input  mmvp_pkg::item_t  item,
  input  logic [3:0]       listen_channel,
  input  logic             full,
  output logic             push,
  output mmvp_pkg::entry_t entry
);
  import mmvp_pkg::*;

  assign item_stall = full;
  assign push       = item_valid && !full;

  always_comb begin
    entry.kind        = K_NOP;
    entry.rs          = RS_NONE;
    entry.midi_byte   = item.midi_byte;
    entry.table_index = item.table_index;
    entry.table_value = item.table_value;
    unique case (item.op)
      OP_TABLE: entry.kind = K_TABLE;
      OP_TICK:  entry.kind = K_TICK;
      OP_MIDI: begin
        if (!item.midi_byte[7]) begin
          entry.kind = K_DATA;
        end else if (item.midi_byte[7:4] != HI_SYSTEM) begin
          entry.kind = K_STATUS;
          if (item.midi_byte[3:0] == listen_channel) begin
            unique case (item.midi_byte[7:4])
              HI_NOTE_ON:  entry.rs = RS_ON;
              HI_NOTE_OFF: entry.rs = RS_OFF;
              HI_CC:       entry.rs = RS_CC;
              HI_BEND:     entry.rs = RS_PB;
              default:     entry.rs = RS_NONE;
            endcase
          end
        end
      end
      default: entry.kind = K_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: src/mmvp_back.sv
// Execution sequencer: voice state, period table, multiply and restoring divider.
// Depends on mmvp_pkg and mmvp_ram.
`default_nettype none

module mmvp_back #(
  parameter int NOTE_COUNT = mmvp_pkg::NOTE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mmvp_pkg::entry_t  entry,
  input  logic              empty,
  output logic              pop,
  input  mmvp_pkg::cfg_t    cfg,
  output logic              result_valid,
  input  logic              result_stall,
  output mmvp_pkg::result_t result
);
  import mmvp_pkg::*;

  localparam int AW = $clog2(NOTE_COUNT);
  localparam logic signed [8:0] LAST = 9'(NOTE_COUNT - 1);
  localparam logic [7:0] COUNT8 = 8'(NOTE_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_MUL, S_SCL, S_DIV, S_FIN, S_DONE
  } state_t;
  typedef enum logic [2:0] {M_NOTE, M_FINE, M_BUP, M_BDN, M_TICK} mode_t;

  state_t             state;
  mode_t              mode;
  rs_t                rs;
  logic               note_cnt;
  logic               cc_cnt;
  logic               bend_cnt;
  logic [6:0]         pending_note;
  logic [6:0]         playing_note;
  logic [6:0]         pending_ctrl;
  logic [15:0]        base_period;
  logic signed [16:0] fine_offset;
  logic               gate;
  logic               sweep_on;
  logic               sweep_rise;
  logic [6:0]         sweep_step;
  logic               sweep_loop;
  logic               tick_div;
  logic [15:0]        compare;
  logic               upd;
  logic               restart;
  logic [AW-1:0]      a_addr;
  logic [AW-1:0]      b_addr;
  logic [15:0]        ta;
  logic [15:0]        tb;
  logic [6:0]         k;
  logic [9:0]         dvs;
  logic [22:0]        dq;
  logic [9:0]         rem;
  logic [4:0]         cnt;

  logic               ram_we;
  logic [AW-1:0]      raddr;
  logic [15:0]        rdata;
  logic signed [8:0]  p9;
  logic [AW-1:0]      pc;
  logic [9:0]         tdiv;
  logic [6:0]         b;
  logic signed [16:0] diff;
  logic               neg;
  logic [15:0]        mag;
  logic [10:0]        trial;
  logic               ge;
  logic [32:0]        fine_prod;
  logic signed [17:0] sq;
  logic signed [16:0] fine_use;
  logic [23:0]        base_sum;
  logic [23:0]        up_lim;
  logic [15:0]        base_new;
  logic signed [19:0] v_base;
  logic signed [19:0] v;
  logic [15:0]        v_sat;

  function automatic logic [AW-1:0] clamp_idx(input logic signed [8:0] n);
    logic [AW-1:0] r;
    if (n < 0) begin
      r = '0;
    end else if (n > LAST) begin
      r = LAST[AW-1:0];
    end else begin
      r = n[AW-1:0];
    end
    return r;
  endfunction

  assign pop    = (state == S_IDLE) && !empty;
  assign ram_we = pop && (entry.kind == K_TABLE) && ({1'b0, entry.table_index} < COUNT8);
  assign raddr  = (state == S_RA) ? a_addr : b_addr;
  assign p9     = $signed({2'b00, playing_note});
  assign pc     = clamp_idx(p9);
  assign tdiv   = (pc == '0) ? 10'd8 : {7'(pc), 3'b000};
  assign b      = entry.midi_byte[6:0];

  mmvp_ram #(.WIDTH(16), .DEPTH(NOTE_COUNT)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry.table_index[AW-1:0]),
    .wdata (entry.table_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (mode)
      M_FINE:  diff = $signed({1'b0, tb}) - $signed({1'b0, ta});
      M_BUP:   diff = $signed({1'b0, ta}) - $signed({1'b0, tb});
      M_BDN:   diff = $signed({1'b0, tb}) - $signed({1'b0, ta});
      default: diff = $signed({1'b0, ta});
    endcase
    neg   = diff[16];
    mag   = neg ? 16'(-diff) : diff[15:0];
    trial = {rem, dq[22]};
    ge    = trial >= {1'b0, dvs};
    fine_prod = {16'b0, dq[22:6]} * {17'b0, FINE_RECIP3};
    sq    = neg ? -$signed({1'b0, dq[16:0]}) : $signed({1'b0, dq[16:0]});
    fine_use = (mode == M_FINE) ? sq[16:0] : fine_offset;

    base_sum = {8'b0, base_period} + {1'b0, dq};
    up_lim   = {8'b0, cfg.min_period} + {1'b0, dq};
    base_new = base_period;
    if (!sweep_rise) begin
      if (base_period < cfg.max_period) begin
        base_new = (base_sum > 24'd65535) ? 16'hFFFF : base_sum[15:0];
      end else if (sweep_loop) begin
        base_new = ta;
      end
    end else begin
      if ({8'b0, base_period} > up_lim) begin
        base_new = base_period - dq[15:0];
      end else if (sweep_loop) begin
        base_new = ta;
      end
    end

    case (mode)
      M_BUP:   v_base = $signed({4'b0, ta}) - {{2{sq[17]}}, sq};
      M_BDN:   v_base = $signed({4'b0, ta}) + {{2{sq[17]}}, sq};
      M_TICK:  v_base = $signed({4'b0, base_new});
      default: v_base = $signed({4'b0, ta});
    endcase
    v = v_base + {{3{fine_use[16]}}, fine_use};
    if (v[19]) begin
      v_sat = 16'd0;
    end else if (v[18:16] != 3'b000) begin
      v_sat = 16'hFFFF;
    end else begin
      v_sat = v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    state_t state_next;
    if (rst) begin
      state        <= S_IDLE;
      mode         <= M_NOTE;
      rs           <= RS_NONE;
      note_cnt     <= 1'b0;
      cc_cnt       <= 1'b0;
      bend_cnt     <= 1'b0;
      pending_note <= '0;
      playing_note <= '0;
      pending_ctrl <= '0;
      base_period  <= '0;
      fine_offset  <= '0;
      gate         <= 1'b0;
      sweep_on     <= 1'b1;
      sweep_rise   <= 1'b1;
      sweep_step   <= '0;
      sweep_loop   <= 1'b1;
      tick_div     <= 1'b0;
      compare      <= RST_PERIOD;
      upd          <= 1'b0;
      restart      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            upd        <= 1'b0;
            restart    <= 1'b0;
            state_next = S_DONE;
            unique case (entry.kind)
              K_TICK: begin
                if (sweep_on && (sweep_step != '0) && gate) begin
                  if (!tick_div) begin
                    tick_div <= 1'b1;
                  end else begin
                    tick_div   <= 1'b0;
                    mode       <= M_TICK;
                    a_addr     <= pc;
                    b_addr     <= pc;
                    k          <= sweep_step;
                    dvs        <= tdiv;
                    state_next = S_RA;
                  end
                end
              end
              K_STATUS: rs <= entry.rs;
              K_DATA: begin
                unique case (rs)
                  RS_ON: begin
                    if (note_cnt) begin
                      note_cnt <= 1'b0;
                      if (b != '0) begin
                        mode       <= M_NOTE;
                        a_addr     <= clamp_idx($signed({2'b00, pending_note}));
                        b_addr     <= clamp_idx($signed({2'b00, pending_note}));
                        state_next = S_RA;
                      end else if (pending_note == playing_note) begin
                        gate <= 1'b0;
                      end
                    end else begin
                      pending_note <= b;
                      note_cnt     <= 1'b1;
                    end
                  end
                  RS_OFF: begin
                    if (note_cnt) begin
                      note_cnt <= 1'b0;
                    end else begin
                      if (b == playing_note) begin
                        gate <= 1'b0;
                      end
                      note_cnt <= 1'b1;
                    end
                  end
                  RS_CC: begin
                    if (cc_cnt) begin
                      cc_cnt <= 1'b0;
                      if (pending_ctrl == cfg.fine_ctrl) begin
                        mode       <= M_FINE;
                        a_addr     <= pc;
                        b_addr     <= clamp_idx(p9 - 9'sd1);
                        k          <= b;
                        state_next = S_RA;
                      end else if (pending_ctrl == cfg.sweep_enable_cc) begin
                        sweep_on <= b > CC_THRESH;
                      end else if (pending_ctrl == cfg.dir_ctrl) begin
                        sweep_rise <= b > CC_THRESH;
                      end else if (pending_ctrl == cfg.step_ctrl) begin
                        sweep_step <= b;
                      end else if (pending_ctrl == cfg.sweep_loop_cc) begin
                        sweep_loop <= b > CC_THRESH;
                      end
                    end else begin
                      pending_ctrl <= b;
                      cc_cnt       <= 1'b1;
                    end
                  end
                  RS_PB: begin
                    if (bend_cnt) begin
                      bend_cnt <= 1'b0;
                      if (b > BEND_MID) begin
                        mode       <= M_BUP;
                        a_addr     <= pc;
                        b_addr     <= clamp_idx(p9 + 9'sd2);
                        k          <= b - BEND_MID;
                        state_next = S_RA;
                      end else if ((b < BEND_MID) && (playing_note > 7'd1)) begin
                        mode       <= M_BDN;
                        a_addr     <= pc;
                        b_addr     <= clamp_idx(p9 - 9'sd2);
                        k          <= BEND_SPAN - b;
                        state_next = S_RA;
                      end
                    end else begin
                      bend_cnt <= 1'b1;
                    end
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
            state <= state_next;
          end
        end
        S_RA: state <= S_RB;
        S_RB: begin
          ta    <= rdata;
          state <= S_RC;
        end
        S_RC: begin
          tb    <= rdata;
          state <= (mode == M_NOTE) ? S_FIN : S_MUL;
        end
        S_MUL: begin
          dq    <= {7'b0, mag} * {16'b0, k};
          rem   <= '0;
          cnt   <= '0;
          state <= (mode == M_TICK) ? S_DIV : S_SCL;
        end
        S_SCL: begin
          // fine pitch divides by 192, pitch bend by 64
          if (mode == M_FINE) begin
            dq <= {7'b0, fine_prod[32:17]};
          end else begin
            dq <= {6'b0, dq[22:6]};
          end
          state <= S_FIN;
        end
        S_DIV: begin
          dq  <= {dq[21:0], ge};
          rem <= ge ? 10'(trial - {1'b0, dvs}) : trial[9:0];
          cnt <= cnt + 5'd1;
          if (cnt == 5'd22) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          compare <= v_sat;
          upd     <= 1'b1;
          case (mode)
            M_NOTE: begin
              base_period  <= ta;
              playing_note <= pending_note;
              gate         <= 1'b1;
              restart      <= 1'b1;
            end
            M_FINE: fine_offset <= sq[16:0];
            M_TICK: base_period <= base_new;
            default: ;
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid          <= 1'b1;
            result.period_out     <= compare;
            result.period_updated <= upd;
            result.gate           <= gate;
            result.phase_restart  <= restart;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dvs != '0))
    else $error("divide with zero divisor");
  a_restart_gate: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.phase_restart) |-> (result.gate && result.period_updated))
    else $error("phase restart without gate and period update");
  a_rise_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside completion");

endmodule

`default_nettype wire

// File: src/midi_mono_voice_pitch_controller_core.sv
// Top level of the mono MIDI voice pitch controller: config registers and wiring.
// Depends on mmvp_pkg, mmvp_front, mmvp_fifo and mmvp_back.
`default_nettype none

// Monophonic MIDI voice: takes MIDI bytes, sweep ticks and period-table writes and
// returns one result per transaction. Load the table before playing notes. Inputs
// pass a classifier into a two-entry queue; a sequencer runs them one at a time.
// From accepting a transaction to raising result_valid, simple ones read no table;
// a note on makes two table RAM reads; fine pitch and pitch bend add a multiply and
// a constant scaling; a sweep step adds a multiply and a bit-serial divider. A stalled
// result holds the sequencer for the length of the stall. Write config only while idle.
module midi_mono_voice_pitch_controller_core #(
  parameter int NOTE_COUNT = mmvp_pkg::NOTE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  mmvp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output mmvp_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import mmvp_pkg::*;

  cfg_t   cfg;
  logic   full;
  logic   push;
  logic   pop;
  logic   empty;
  entry_t f_entry;
  entry_t q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listen_channel  <= RST_LISTEN;
      cfg.fine_ctrl       <= RST_FINE_CC;
      cfg.sweep_enable_cc <= RST_EN_CC;
      cfg.dir_ctrl        <= RST_DIR_CC;
      cfg.step_ctrl       <= RST_AMT_CC;
      cfg.sweep_loop_cc   <= RST_LOOP_CC;
      cfg.min_period      <= RST_MIN_PER;
      cfg.max_period      <= RST_MAX_PER;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_LISTEN:  cfg.listen_channel  <= cfg_data[3:0];
        REG_FINE_CC: cfg.fine_ctrl       <= cfg_data[6:0];
        REG_EN_CC:   cfg.sweep_enable_cc <= cfg_data[6:0];
        REG_DIR_CC:  cfg.dir_ctrl        <= cfg_data[6:0];
        REG_AMT_CC:  cfg.step_ctrl       <= cfg_data[6:0];
        REG_LOOP_CC: cfg.sweep_loop_cc   <= cfg_data[6:0];
        REG_MIN_PER: cfg.min_period      <= cfg_data;
        REG_MAX_PER: cfg.max_period      <= cfg_data;
        default: ;
      endcase
    end
  end

  mmvp_front u_front (
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .listen_channel (cfg.listen_channel),
    .full           (full),
    .push           (push),
    .entry          (f_entry)
  );

  mmvp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_entry),
    .full  (full),
    .pop   (pop),
    .rdata (q_entry),
    .empty (empty)
  );

  mmvp_back #(.NOTE_COUNT(NOTE_COUNT)) u_back (
    .clk          (clk),
    .rst          (rst),
    .entry        (q_entry),
    .empty        (empty),
    .pop          (pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_midi_mono_voice_pitch_controller_core.sv
// Self-checking testbench for midi_mono_voice_pitch_controller_core.
// Depends on mmvp_pkg; a predictor class mirrors the voice state and checks
// every result against its own expectation.

module tb_midi_mono_voice_pitch_controller_core;
  import mmvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NOTES = 128;

  class voice_predictor;
    logic [15:0] regs [8];
    logic [15:0] period_table [NOTES];
    rs_t status;
    bit note_cnt, cc_cnt, bend_cnt;
    logic [6:0] pending_note, playing_note, pending_ctrl;
    logic [15:0] base_period, compare_period;
    int fine_offset;
    bit gate, sweep_on, sweep_rise, sweep_loop, tick_div;
    logic [6:0] sweep_step;
    result_t expected_results[$];
    int errors;

    function new();
      regs[REG_LISTEN] = 16'(RST_LISTEN);
      regs[REG_FINE_CC] = 16'(RST_FINE_CC);
      regs[REG_EN_CC] = 16'(RST_EN_CC);
      regs[REG_DIR_CC] = 16'(RST_DIR_CC);
      regs[REG_AMT_CC] = 16'(RST_AMT_CC);
      regs[REG_LOOP_CC] = 16'(RST_LOOP_CC);
      regs[REG_MIN_PER] = RST_MIN_PER;
      regs[REG_MAX_PER] = RST_MAX_PER;
      foreach (period_table[i]) period_table[i] = '0;
      status = RS_NONE;
      {note_cnt, cc_cnt, bend_cnt} = '0;
      {pending_note, playing_note, pending_ctrl} = '0;
      base_period = '0;
      compare_period = RST_PERIOD;
      fine_offset = 0;
      gate = 0;
      sweep_on = 1;
      sweep_rise = 1;
      sweep_loop = 1;
      sweep_step = '0;
      tick_div = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_t idx, logic [15:0] data);
      logic [15:0] mask;
      case (idx)
        REG_LISTEN: mask = 16'h000F;
        REG_MIN_PER, REG_MAX_PER: mask = 16'hFFFF;
        default: mask = 16'h007F;
      endcase
      regs[idx] = data & mask;
    endfunction

    function longint period_of(longint n);
      if (n < 0) n = 0;
      if (n > NOTES - 1) n = NOTES - 1;
      return longint'(period_table[n]);
    endfunction

    function void set_compare(longint v);
      v = v + fine_offset;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      compare_period = v[15:0];
    endfunction

    function bit apply_cc(logic [7:0] data);
      longint p;
      p = longint'(playing_note);
      cc_cnt = 0;
      if (pending_ctrl == regs[REG_FINE_CC]) begin
        fine_offset = int'(((period_of(p - 1) - period_of(p)) * longint'(data)) / 192);
        set_compare(period_of(p));
        return 1;
      end
      if (pending_ctrl == regs[REG_EN_CC]) sweep_on = data > 64;
      else if (pending_ctrl == regs[REG_DIR_CC]) sweep_rise = data > 64;
      else if (pending_ctrl == regs[REG_AMT_CC]) sweep_step = data[6:0];
      else if (pending_ctrl == regs[REG_LOOP_CC]) sweep_loop = data > 64;
      return 0;
    endfunction

    function bit apply_bend(logic [7:0] msb);
      longint p, d;
      p = longint'(playing_note);
      bend_cnt = 0;
      if (msb > 63) begin
        d = ((period_of(p) - period_of(p + 2)) * longint'(msb - 63)) / 64;
        set_compare(period_of(p) - d);
        return 1;
      end
      if (msb < 63 && p > 1) begin
        d = ((period_of(p - 2) - period_of(p)) * longint'(64 - msb)) / 64;
        set_compare(period_of(p) + d);
        return 1;
      end
      return 0;
    endfunction

    function bit apply_tick();
      longint p, dv, step, base;
      p = longint'(playing_note);
      if (!(sweep_on && sweep_step > 0 && gate)) return 0;
      if (!tick_div) begin
        tick_div = 1;
        return 0;
      end
      tick_div = 0;
      dv = 8 * p;
      if (dv == 0) dv = 8;
      step = (longint'(sweep_step) * period_of(p)) / dv;
      base = longint'(base_period);
      if (!sweep_rise) begin
        if (base < longint'(regs[REG_MAX_PER])) begin
          base = base + step;
          if (base > 65535) base = 65535;
        end else if (sweep_loop) begin
          base = period_of(p);
        end
      end else begin
        if (base > longint'(regs[REG_MIN_PER]) + step) base = base - step;
        else if (sweep_loop) base = period_of(p);
      end
      base_period = base[15:0];
      set_compare(base);
      return 1;
    endfunction

    function void note_item(item_t it);
      bit upd, restart;
      logic [7:0] b;
      result_t r;
      upd = 0;
      restart = 0;
      b = it.midi_byte;
      if (it.op == OP_TABLE) begin
        period_table[it.table_index] = it.table_value;
      end else if (it.op == OP_TICK) begin
        upd = apply_tick();
      end else if (it.op == OP_MIDI && b[7:4] != HI_SYSTEM) begin
        if (b[7]) begin
          if (b[3:0] != regs[REG_LISTEN][3:0]) status = RS_NONE;
          else case (b[7:4])
            HI_NOTE_ON: status = RS_ON;
            HI_NOTE_OFF: status = RS_OFF;
            HI_CC: status = RS_CC;
            HI_BEND: status = RS_PB;
            default: status = RS_NONE;
          endcase
        end else begin
          case (status)
            RS_ON: begin
              if (note_cnt) begin
                if (b > 0) begin
                  playing_note = pending_note;
                  base_period = 16'(period_of(longint'(pending_note)));
                  set_compare(longint'(base_period));
                  gate = 1;
                  upd = 1;
                  restart = 1;
                end else if (pending_note == playing_note) begin
                  gate = 0;
                end
                note_cnt = 0;
              end else begin
                pending_note = b[6:0];
                note_cnt = 1;
              end
            end
            RS_OFF: begin
              if (note_cnt) begin
                note_cnt = 0;
              end else begin
                if (b[6:0] == playing_note) gate = 0;
                note_cnt = 1;
              end
            end
            RS_CC: begin
              if (cc_cnt) begin
                upd = apply_cc(b);
              end else begin
                pending_ctrl = b[6:0];
                cc_cnt = 1;
              end
            end
            RS_PB: begin
              if (bend_cnt) upd = apply_bend(b);
              else bend_cnt = 1;
            end
            default: ;
          endcase
        end
      end
      r.period_out = compare_period;
      r.period_updated = upd;
      r.gate = gate;
      r.phase_restart = restart;
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result with no transaction pending: %p", got);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.period_out !== exp_r.period_out) begin
        $error("period_out expected %0d actual %0d", exp_r.period_out, got.period_out);
        errors++;
      end
      if (got.period_updated !== exp_r.period_updated) begin
        $error("period_updated expected %0d actual %0d", exp_r.period_updated,
               got.period_updated);
        errors++;
      end
      if (got.gate !== exp_r.gate) begin
        $error("gate expected %0d actual %0d", exp_r.gate, got.gate);
        errors++;
      end
      if (got.phase_restart !== exp_r.phase_restart) begin
        $error("phase_restart expected %0d actual %0d", exp_r.phase_restart,
               got.phase_restart);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 0;
  result_t result;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  voice_predictor voice = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  midi_mono_voice_pitch_controller_core uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    result_stall = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) voice.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 0;
      @(negedge clk);
    end
    item = it;
    item_valid = 1;
    do @(posedge clk); while (item_stall);
    voice.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_op(op_t op, logic [7:0] b);
    item_t it;
    it.op = op;
    it.midi_byte = b;
    it.table_index = 7'($urandom_range(127));
    it.table_value = 16'($urandom);
    send_item(it);
  endtask

  task automatic send_table(logic [6:0] idx, logic [15:0] val);
    item_t it;
    it.op = OP_TABLE;
    it.midi_byte = 8'($urandom);
    it.table_index = idx;
    it.table_value = val;
    send_item(it);
  endtask

  task automatic send_midi(logic [7:0] b);
    send_op(OP_MIDI, b);
  endtask

  task automatic wait_idle();
    item_valid = 0;
    while (voice.expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(reg_t idx, logic [15:0] data);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 0;
    voice.write_reg(idx, data);
  endtask

  task automatic configure(logic [3:0] ch, logic [6:0] c1, logic [6:0] c2, logic [6:0] c3,
                           logic [6:0] c4, logic [6:0] c5, logic [15:0] lo,
                           logic [15:0] hi);
    wait_idle();
    write_reg(REG_LISTEN, 16'(ch));
    write_reg(REG_FINE_CC, 16'(c1));
    write_reg(REG_EN_CC, 16'(c2));
    write_reg(REG_DIR_CC, 16'(c3));
    write_reg(REG_AMT_CC, 16'(c4));
    write_reg(REG_LOOP_CC, 16'(c5));
    write_reg(REG_MIN_PER, lo);
    write_reg(REG_MAX_PER, hi);
  endtask

  function automatic logic [7:0] status_byte(logic [3:0] hi);
    logic [3:0] ch;
    ch = voice.regs[REG_LISTEN][3:0];
    if ($urandom_range(99) < 8) ch = 4'($urandom);
    return {hi, ch};
  endfunction

  function automatic logic [7:0] data_byte();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd127;
      2: return 8'(8'd64 + $urandom_range(1));
      default: return 8'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [7:0] some_controller();
    if ($urandom_range(99) < 75) return voice.regs[1 + $urandom_range(4)][7:0];
    return 8'($urandom_range(127));
  endfunction

  task automatic play_random(int count);
    int n;
    n = 0;
    while (n < count) begin
      case ($urandom_range(99)) inside
        [0:29]: begin
          if ($urandom_range(3) != 0) send_midi(status_byte(HI_NOTE_ON));
          send_midi(data_byte());
          send_midi(($urandom_range(9) == 0) ? 8'd0 : data_byte());
          n += 3;
        end
        [30:39]: begin
          send_midi(status_byte(HI_NOTE_OFF));
          send_midi($urandom_range(3) == 0 ? {1'b0, voice.playing_note} : data_byte());
          send_midi(data_byte());
          n += 3;
        end
        [40:59]: begin
          if ($urandom_range(3) != 0) send_midi(status_byte(HI_CC));
          send_midi(some_controller());
          send_midi(data_byte());
          n += 3;
        end
        [60:69]: begin
          send_midi(status_byte(HI_BEND));
          send_midi(data_byte());
          send_midi(data_byte());
          n += 3;
        end
        [70:89]: begin
          repeat (1 + $urandom_range(6)) begin
            send_op(OP_TICK, 8'($urandom));
            n++;
          end
        end
        [90:94]: begin
          send_table(7'($urandom_range(127)), 16'($urandom));
          n++;
        end
        default: begin
          case ($urandom_range(3))
            0: send_midi(8'(8'hF0 + $urandom_range(15)));
            1: send_op(OP_NOP, 8'($urandom));
            2: send_midi({4'(4'hA + $urandom_range(2)), 4'($urandom)});
            default: send_midi(8'($urandom));
          endcase
          n++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 0;

    for (int i = 0; i < NOTES; i++) begin
      case (i)
        0, 60: send_table(7'(i), 16'hFFFF);
        61, 127: send_table(7'(i), 16'h0000);
        default: send_table(7'(i), 16'($urandom));
      endcase
    end

    // directed: extremes of notes, controllers, bend and sweep
    send_midi(8'h90);
    send_midi(8'd0);
    send_midi(8'd127);
    send_midi(8'd127);
    send_midi(8'd1);
    send_midi(8'hB0);
    send_midi(8'd1);
    send_midi(8'd127);
    send_midi(8'd4);
    send_midi(8'd127);
    send_op(OP_TICK, 8'h00);
    send_op(OP_TICK, 8'hFF);
    send_midi(8'hE0);
    send_midi(8'd0);
    send_midi(8'd0);
    send_midi(8'd5);
    send_midi(8'd63);
    send_midi(8'd5);
    send_midi(8'd127);
    send_midi(8'hF8);
    send_midi(8'h93);
    send_midi(8'h80);
    send_midi(8'd127);
    send_midi(8'd0);
    send_op(OP_NOP, 8'hFF);

    play_random(400);

    send_idle_pct = 72;
    configure(4'd15, 7'd127, 7'd0, 7'd64, 7'd100, 7'd126, 16'd0, 16'd65535);
    play_random(400);

    send_idle_pct = 0;
    recv_stall_pct = 72;
    configure(4'd7, 7'd10, 7'd10, 7'd11, 7'd11, 7'd12, 16'd65535, 16'd0);
    play_random(400);

    send_idle_pct = 16;
    recv_stall_pct = 16;
    configure(4'($urandom), 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
              7'($urandom), 16'($urandom), 16'($urandom));
    play_random(400);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(RST_LISTEN, RST_FINE_CC, RST_EN_CC, RST_DIR_CC, RST_AMT_CC, RST_LOOP_CC,
              RST_MIN_PER, RST_MAX_PER);
    play_random(400);

    wait_idle();
    if (voice.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
src/mmvp_pkg.sv
src/mmvp_ram.sv
src/mmvp_fifo.sv
src/mmvp_front.sv
src/mmvp_back.sv
src/midi_mono_voice_pitch_controller_core.sv
tb/sv/tb_midi_mono_voice_pitch_controller_core.sv
